[sv/lrp_pkg.sv]
package lrp_pkg;

  localparam int DEF_NUM_STATES  = 256;
  localparam int DEF_NUM_SYMBOLS = 128;
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_MAX_REDUCES = 15;

  // Depths of the command and result queues (powers of two).
  localparam int CMD_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH = 4;

  // Widest row and column indexes the parameter ranges allow.
  localparam int ROW_MAX_W = 12;
  localparam int COL_MAX_W = 10;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_TOKEN   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_TOKEN,
    OP_RESTART
  } op_t;

  typedef enum logic [1:0] {
    ET_EMPTY  = 2'd0,
    ET_SHIFT  = 2'd1,
    ET_REDUCE = 2'd2,
    ET_ACCEPT = 2'd3
  } etype_t;

  typedef enum logic [1:0] {
    ST_REDUCED  = 2'd0,
    ST_SHIFTED  = 2'd1,
    ST_ACCEPTED = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RR_NO_ENTRY  = 3'd0,
    RR_GOTO      = 3'd1,
    RR_OVERFLOW  = 3'd2,
    RR_UNDERFLOW = 3'd3,
    RR_TOO_MANY  = 3'd4,
    RR_FINISHED  = 3'd5
  } reason_t;

  typedef struct packed {
    logic [6:0] nt;
    logic [3:0] pops;
    logic [7:0] target;
    etype_t     etype;
  } entry_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] row;
    logic [6:0] sym;
    entry_t     entry;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] nt;
    logic [3:0] popped;
    reason_t    reason;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_ACT,
    S_POP,
    S_TOP,
    S_GLOOK,
    S_GACT
  } state_t;

endpackage

[sv/lrp_fifo.sv]
module lrp_fifo import lrp_pkg::*; #(
  parameter type T     = logic,
  parameter int  DEPTH = CMD_Q_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);

  T               mem [DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [AW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

endmodule

[sv/lrp_front.sv]
module lrp_front import lrp_pkg::*; #(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind,
  input  logic [7:0] state_index,
  input  logic [6:0] symbol,
  input  logic [1:0] entry_type,
  input  logic [7:0] target_state,
  input  logic [3:0] pop_count,
  input  logic [6:0] reduced_symbol,
  input  logic       clearing,
  output cmd_t       cmd,
  output logic       cmd_empty,
  input  logic       cmd_pop
);

  cmd_t cmd_in;
  logic keep;
  logic q_full;
  logic in_range;

  assign in_range = (32'(state_index) < NUM_STATES) && (32'(symbol) < NUM_SYMBOLS);

  // Unused kinds and writes outside the table are dropped here.
  always_comb begin
    cmd_in.row          = state_index;
    cmd_in.sym          = symbol;
    cmd_in.entry.etype  = etype_t'(entry_type);
    cmd_in.entry.target = target_state;
    cmd_in.entry.pops   = pop_count;
    cmd_in.entry.nt     = reduced_symbol;
    unique case (kind)
      KIND_WRITE: begin
        cmd_in.op = OP_WRITE;
        keep      = in_range;
      end
      KIND_TOKEN: begin
        cmd_in.op = OP_TOKEN;
        keep      = 1'b1;
      end
      KIND_RESTART: begin
        cmd_in.op = OP_RESTART;
        keep      = 1'b1;
      end
      default: begin
        cmd_in.op = OP_RESTART;
        keep      = 1'b0;
      end
    endcase
  end

  assign full = q_full || clearing;

  lrp_fifo #(.T(cmd_t), .DEPTH(CMD_Q_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full && keep),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

[sv/lrp_engine.sv]
module lrp_engine import lrp_pkg::*; #(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int MAX_REDUCES = DEF_MAX_REDUCES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  cmd_t       cmd,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  output logic       clearing,
  output logic       res_push,
  output result_t    res,
  input  logic       res_full
);

  localparam int SW  = $clog2(NUM_STATES);
  localparam int YW  = $clog2(NUM_SYMBOLS);
  localparam int TAW = SW + YW;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int RW  = $clog2(MAX_REDUCES + 1);

  state_t          state;
  state_t          state_next;

  entry_t          tbl [2**TAW];
  entry_t          tbl_q;
  logic            tbl_we;
  logic [TAW-1:0]  tbl_waddr;
  entry_t          tbl_wdata;
  logic [TAW-1:0]  tbl_raddr;
  logic [TAW-1:0]  clr_addr;

  logic [7:0]      stk [STACK_DEPTH];
  logic [7:0]      stk_q;
  logic            stk_we;
  logic [7:0]      stk_wdata;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [7:0]      top;
  logic            finished;
  logic [7:0]      start_state;
  logic [6:0]      tok_sym;
  logic [6:0]      red_nt;
  logic [3:0]      red_pops;
  logic [RW-1:0]   reductions;
  logic            oob;

  logic [7:0]      cur;
  logic [6:0]      look_sym;
  logic [ROW_MAX_W-1:0] cur_w;
  logic [COL_MAX_W-1:0] look_w;
  logic [ROW_MAX_W-1:0] row_w;
  logic [COL_MAX_W-1:0] col_w;
  entry_t          ent;
  logic            stack_full;
  logic            reduce_ok;
  logic            goto_ok;
  logic            done;

  // The action read address is held through a stall in S_ACT so the entry stays put.
  assign cur        = (count == '0) ? start_state : top;
  assign look_sym   = (state == S_LOOK || state == S_ACT) ? tok_sym : red_nt;
  assign cur_w      = ROW_MAX_W'(cur);
  assign look_w     = COL_MAX_W'(look_sym);
  assign row_w      = ROW_MAX_W'(cmd.row);
  assign col_w      = COL_MAX_W'(cmd.sym);
  assign ent        = oob ? entry_t'('0) : tbl_q;
  assign stack_full = (32'(count) >= STACK_DEPTH);
  assign reduce_ok  = (ent.etype == ET_REDUCE) && (32'(reductions) < MAX_REDUCES)
                      && (32'(ent.pops) <= 32'(count));
  assign goto_ok    = (ent.etype == ET_SHIFT) && !stack_full;
  assign count_next = count - CW'(ent.pops);
  assign done       = (clr_addr == {TAW{1'b1}});
  assign clearing   = (state == S_CLEAR);
  assign tbl_raddr  = {cur_w[SW-1:0], look_w[YW-1:0]};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (done) state_next = S_IDLE;
      S_IDLE: begin
        if (!cmd_empty && cmd.op == OP_TOKEN && !finished) state_next = S_LOOK;
      end
      S_LOOK: state_next = S_ACT;
      S_ACT: begin
        if (!res_full) begin
          if (reduce_ok) state_next = (count_next == '0) ? S_GLOOK : S_POP;
          else state_next = S_IDLE;
        end
      end
      S_POP:   state_next = S_TOP;
      S_TOP:   state_next = S_GLOOK;
      S_GLOOK: state_next = S_GACT;
      S_GACT: begin
        if (!res_full) state_next = goto_ok ? S_LOOK : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: queue pops, result pushes, table and stack writes.
  always_comb begin
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    res.status   = ST_REJECTED;
    res.last     = 1'b1;
    tbl_we       = 1'b0;
    tbl_waddr    = {row_w[SW-1:0], col_w[YW-1:0]};
    tbl_wdata    = cmd.entry;
    stk_we       = 1'b0;
    stk_wdata    = ent.target;
    unique case (state)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_addr;
        tbl_wdata = '0;
      end
      S_IDLE: begin
        if (!cmd_empty) begin
          priority if (cmd.op == OP_WRITE) begin
            cmd_pop = 1'b1;
            tbl_we  = 1'b1;
          end else if (cmd.op == OP_TOKEN) begin
            cmd_pop = !finished || !res_full;
            if (finished && !res_full) begin
              res_push   = 1'b1;
              res.reason = RR_FINISHED;
            end
          end else begin
            cmd_pop = 1'b1;
          end
        end
      end
      S_ACT: begin
        if (!res_full && !reduce_ok) begin
          res_push = 1'b1;
          unique case (ent.etype)
            ET_EMPTY:  res.reason = RR_NO_ENTRY;
            ET_ACCEPT: res.status = ST_ACCEPTED;
            ET_SHIFT: begin
              if (stack_full) res.reason = RR_OVERFLOW;
              else begin
                res.status = ST_SHIFTED;
                stk_we     = 1'b1;
              end
            end
            default: begin
              if (32'(reductions) >= MAX_REDUCES) res.reason = RR_TOO_MANY;
              else res.reason = RR_UNDERFLOW;
            end
          endcase
        end
      end
      S_GACT: begin
        if (!res_full) begin
          res_push = 1'b1;
          priority if (ent.etype == ET_EMPTY) res.reason = RR_NO_ENTRY;
          else if (ent.etype != ET_SHIFT) res.reason = RR_GOTO;
          else if (stack_full) res.reason = RR_OVERFLOW;
          else begin
            res.status = ST_REDUCED;
            res.nt     = red_nt;
            res.popped = red_pops;
            res.last   = 1'b0;
            stk_we     = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_waddr] <= tbl_wdata;
    tbl_q <= tbl[tbl_raddr];
  end

  // The stack is written at the current count and read one below it.
  always_ff @(posedge clk) begin
    if (stk_we) stk[count[AW-1:0]] <= stk_wdata;
    stk_q <= stk[AW'(count - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      count       <= '0;
      finished    <= 1'b0;
      start_state <= '0;
      reductions  <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) start_state <= cfg_wr_data;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == S_IDLE && !cmd_empty && cmd.op == OP_RESTART) begin
        count    <= '0;
        finished <= 1'b0;
      end
      if (state == S_IDLE && !cmd_empty && cmd.op == OP_TOKEN) reductions <= '0;
      if (stk_we) begin
        count <= count + 1'b1;
        top   <= ent.target;
      end
      if (res_push && res.last && res.status != ST_SHIFTED) finished <= 1'b1;
      if (state == S_ACT && !res_full && reduce_ok) begin
        count    <= count_next;
        red_nt   <= ent.nt;
        red_pops <= ent.pops;
      end
      if (state == S_GACT && !res_full && goto_ok) reductions <= reductions + 1'b1;
      if (state == S_TOP) top <= stk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) tok_sym <= cmd.sym;
    if (state == S_LOOK || state == S_GLOOK) begin
      oob <= !((32'(cur) < NUM_STATES) && (32'(look_sym) < NUM_SYMBOLS));
    end
  end

endmodule

[sv/lr_parse_engine.sv]
// Channel   Handshake           Payload
// input     push / full         kind, state_index, symbol, entry_type, target_state,
//                               pop_count, reduced_symbol
// result    empty / pop         status, reduced_nonterminal, popped, reject_reason, last
// config    cfg_wr_en           cfg_wr_data (start state)
//
// After reset the table is cleared one entry a cycle, all 2**(clog2(NUM_STATES) +
// clog2(NUM_SYMBOLS)) entries (32768 by default), with full held high.
// Table writes and restarts are handled straight from S_IDLE in the back end; a
// token passes S_LOOK and S_ACT to a shift, accept or reject, and each reduction
// adds S_GLOOK and S_GACT for the goto, with S_POP and S_TOP first when the stack
// stays non-empty, set by the single table read port and the registered stack
// read. Small queues on both sides let input and results stall independently.
module lr_parse_engine import lrp_pkg::*; #(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int MAX_REDUCES = DEF_MAX_REDUCES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind,
  input  logic [7:0] state_index,
  input  logic [6:0] symbol,
  input  logic [1:0] entry_type,
  input  logic [7:0] target_state,
  input  logic [3:0] pop_count,
  input  logic [6:0] reduced_symbol,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status,
  output logic [6:0] reduced_nonterminal,
  output logic [3:0] popped,
  output logic [2:0] reject_reason,
  output logic       last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  cmd_t    cmd;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    clearing;
  logic    res_push;
  result_t res_in;
  result_t res_out;
  logic    res_full;

  lrp_front #(.NUM_STATES(NUM_STATES), .NUM_SYMBOLS(NUM_SYMBOLS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .kind           (kind),
    .state_index    (state_index),
    .symbol         (symbol),
    .entry_type     (entry_type),
    .target_state   (target_state),
    .pop_count      (pop_count),
    .reduced_symbol (reduced_symbol),
    .clearing       (clearing),
    .cmd            (cmd),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop)
  );

  lrp_engine #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_REDUCES (MAX_REDUCES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .clearing    (clearing),
    .res_push    (res_push),
    .res         (res_in),
    .res_full    (res_full)
  );

  lrp_fifo #(.T(result_t), .DEPTH(RES_Q_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign status              = res_out.status;
  assign reduced_nonterminal = res_out.nt;
  assign popped              = res_out.popped;
  assign reject_reason       = res_out.reason;
  assign last                = res_out.last;

endmodule
